/* rtl/ajb_pkg.sv */
// ajb_pkg: constants, codes and control structs of the audio jitter buffer playout block
// no dependencies
package ajb_pkg;

    localparam int NUM_PKTS     = 64;
    localparam int PKT_SAMPLES  = 512;
    localparam int MAX_CHANNELS = 8;

    localparam int SLOT_W = $clog2(NUM_PKTS);
    localparam int POS_W  = $clog2(PKT_SAMPLES + 1);
    localparam int OFS_W  = POS_W + 1;
    localparam int CNT_W  = 7;
    localparam int CH_W   = 3;
    localparam int NC_W   = 4;
    localparam int ADDR_W = $clog2(NUM_PKTS * PKT_SAMPLES);
    localparam int IDX_W  = 2;
    localparam int DATA_W = 8;

    localparam int TH_DEPLETED   = NUM_PKTS / 32;
    localparam int TH_UNDER_PER  = NUM_PKTS / 16;
    localparam int TH_OVER_PER   = NUM_PKTS / 2;
    localparam int TH_UNDER_PLAY = NUM_PKTS / 8;
    localparam int TH_OVER_PLAY  = NUM_PKTS / 4;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_PERIOD = 2'd1;
    localparam logic [1:0] CMD_PLAY   = 2'd2;

    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_PERIOD = 2'd2;

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_UNDER    = 2'd1;
    localparam logic [1:0] MODE_OVER     = 2'd2;
    localparam logic [1:0] MODE_DEPLETED = 2'd3;

    localparam logic [IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [IDX_W-1:0] REG_CHANNEL_MASK = 2'd1;

    typedef struct packed {
        logic capture;
        logic do_write;
        logic do_period;
        logic play_chk;
        logic play_cap;
        logic play_adj;
        logic emit;
    } ajb_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       eop;
        logic       ch_last;
        logic       out_free;
    } ajb_status_t;

endpackage

/* rtl/ajb_in_if.sv */
// ajb_in_if: input word channel, valid/ready with item payload
// no dependencies
interface ajb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] sample_word;
    logic        end_of_packet;

    modport source (output valid, cmd, sample_word, end_of_packet, input ready);
    modport sink (input valid, cmd, sample_word, end_of_packet, output ready);
endinterface

/* rtl/ajb_out_if.sv */
// ajb_out_if: result word channel, valid/ready with result payload
// no dependencies
interface ajb_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] audio_sample;
    logic [2:0]         channel_index;
    logic               last;
    logic [1:0]         play_state;
    logic [6:0]         fill_level;
    logic               packet_dropped;

    modport source (output valid, kind, audio_sample, channel_index, last, play_state,
                    fill_level, packet_dropped, input ready);
    modport sink (input valid, kind, audio_sample, channel_index, last, play_state,
                  fill_level, packet_dropped, output ready);
endinterface

/* rtl/ajb_ram.sv */
// ajb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ajb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/ajb_ctrl.sv */
// ajb_ctrl: sequencer for write, period and play items
// depends on ajb_pkg
module ajb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ajb_pkg::ajb_status_t status,
    output ajb_pkg::ajb_cmd_t    cmd
);
    import ajb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_WRITE  = 8'b00000010,
        ST_PERIOD = 8'b00000100,
        ST_LEN    = 8'b00001000,
        ST_CHK    = 8'b00010000,
        ST_CAP    = 8'b00100000,
        ST_ADJ    = 8'b01000000,
        ST_EMIT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN:
            begin
                case (status.cmd)
                    CMD_WRITE:  state_next = ST_WRITE;
                    CMD_PERIOD: state_next = ST_PERIOD;
                    CMD_PLAY:   state_next = ST_CHK;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_WRITE:
            begin
                if (!status.eop || status.out_free)
                begin
                    cmd.do_write = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PERIOD:
            begin
                if (status.out_free)
                begin
                    cmd.do_period = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHK:
            begin
                cmd.play_chk = 1'b1;
                state_next   = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.play_cap = 1'b1;
                state_next   = status.ch_last ? ST_ADJ : ST_CHK;
            end
            ST_ADJ:
            begin
                cmd.play_adj = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.ch_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/ajb_dp.sv */
// ajb_dp: packet ring, sample store, play state and result register
// depends on ajb_pkg and ajb_ram
module ajb_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ajb_pkg::ajb_cmd_t            cmd,
    output ajb_pkg::ajb_status_t         status,
    input  logic [1:0]                   in_cmd,
    input  logic [15:0]                  in_sample_word,
    input  logic                         in_end_of_packet,
    input  logic                         wr_en,
    input  logic [ajb_pkg::IDX_W-1:0]    wr_index,
    input  logic [ajb_pkg::DATA_W-1:0]   wr_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   out_kind,
    output logic signed [15:0]           out_audio_sample,
    output logic [2:0]                   out_channel_index,
    output logic                         out_last,
    output logic [1:0]                   out_play_state,
    output logic [6:0]                   out_fill_level,
    output logic                         out_packet_dropped
);
    import ajb_pkg::*;

    logic [1:0]  cmd_reg;
    logic [15:0] word_reg;
    logic        eop_reg;

    logic [NC_W-1:0]   num_channels_reg;
    logic [7:0]        channel_mask_reg;

    logic [SLOT_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;
    logic [OFS_W-1:0]  ofs_reg, ofs_next;
    logic              rvalid_reg, rvalid_next;
    logic [1:0]        mode_reg, mode_next;
    logic              adj_reg, adj_next;
    logic [15:0]       held_reg [MAX_CHANNELS];
    logic [15:0]       held_next [MAX_CHANNELS];
    logic [CH_W-1:0]   j_reg, j_next;
    logic              hit_reg, hit_next;

    logic              ov_reg, ov_next;
    logic [1:0]        o_kind_reg, o_kind_next;
    logic [15:0]       o_smp_reg, o_smp_next;
    logic [2:0]        o_ch_reg, o_ch_next;
    logic              o_last_reg, o_last_next;
    logic [1:0]        o_mode_reg, o_mode_next;
    logic [6:0]        o_fill_reg, o_fill_next;
    logic              o_drop_reg, o_drop_next;

    logic [NC_W-1:0]   nc;
    logic [7:0]        all_mask, sel_mask;
    logic [SLOT_W-1:0] rslot, head_inc, tail_inc, rd_slot;
    logic [OFS_W-1:0]  rd_ofs;
    logic              st_we, len_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [15:0]       st_rdata;
    logic [POS_W-1:0]  len_q, len_wdata;
    logic              out_free;

    always_comb
    begin
        nc = num_channels_reg;
        if (nc == '0)
        begin
            nc = NC_W'(1);
        end
        else if (nc > NC_W'(MAX_CHANNELS))
        begin
            nc = NC_W'(MAX_CHANNELS);
        end
        for (int b = 0; b < 8; b++)
        begin
            all_mask[b] = (NC_W'(b) < nc);
        end
        sel_mask = channel_mask_reg & all_mask;
        if (sel_mask == '0)
        begin
            sel_mask = all_mask;
        end
    end

    assign rslot    = (head_reg == '0) ? SLOT_W'(NUM_PKTS - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == SLOT_W'(NUM_PKTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == SLOT_W'(NUM_PKTS - 1)) ? '0 : tail_reg + 1'b1;
    assign out_free = !ov_reg || out_ready;

    assign st_waddr = ADDR_W'(tail_reg) * ADDR_W'(PKT_SAMPLES) + ADDR_W'(wpos_reg);
    assign st_raddr = ADDR_W'(rd_slot) * ADDR_W'(PKT_SAMPLES) + ADDR_W'(rd_ofs);

    ajb_ram #(.WIDTH(16), .DEPTH(NUM_PKTS * PKT_SAMPLES)) u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (word_reg),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    ajb_ram #(.WIDTH(POS_W), .DEPTH(NUM_PKTS)) u_len (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (tail_reg),
        .wr_data (len_wdata),
        .rd_addr (rslot),
        .rd_data (len_q)
    );

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        wpos_next   = wpos_reg;
        ofs_next    = ofs_reg;
        rvalid_next = rvalid_reg;
        mode_next   = mode_reg;
        adj_next    = adj_reg;
        held_next   = held_reg;
        j_next      = j_reg;
        hit_next    = hit_reg;
        st_we       = 1'b0;
        len_we      = 1'b0;
        len_wdata   = wpos_reg;
        rd_slot     = rslot;
        rd_ofs      = ofs_reg;
        ov_next     = out_ready ? 1'b0 : ov_reg;
        o_kind_next = o_kind_reg;
        o_smp_next  = o_smp_reg;
        o_ch_next   = o_ch_reg;
        o_last_next = o_last_reg;
        o_mode_next = o_mode_reg;
        o_fill_next = o_fill_reg;
        o_drop_next = o_drop_reg;

        if (cmd.capture)
        begin
            j_next = '0;
        end

        if (cmd.do_write)
        begin
            if (wpos_reg < POS_W'(PKT_SAMPLES))
            begin
                st_we     = 1'b1;
                wpos_next = wpos_reg + 1'b1;
            end
            if (eop_reg)
            begin
                len_we      = 1'b1;
                len_wdata   = wpos_next;
                wpos_next   = '0;
                o_drop_next = (tail_inc == head_reg);
                if (tail_inc != head_reg)
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
                ov_next     = 1'b1;
                o_kind_next = KIND_COMMIT;
                o_smp_next  = '0;
                o_ch_next   = '0;
                o_last_next = 1'b1;
                o_mode_next = mode_reg;
                o_fill_next = count_next;
            end
        end

        if (cmd.do_period)
        begin
            adj_next = 1'b0;
            if (mode_reg == MODE_NORMAL)
            begin
                if (count_reg < CNT_W'(TH_DEPLETED))
                begin
                    mode_next = MODE_DEPLETED;
                end
                else if (count_reg < CNT_W'(TH_UNDER_PER))
                begin
                    mode_next = MODE_UNDER;
                end
                else if (count_reg > CNT_W'(TH_OVER_PER))
                begin
                    mode_next = MODE_OVER;
                end
            end
            ov_next     = 1'b1;
            o_kind_next = KIND_PERIOD;
            o_smp_next  = '0;
            o_ch_next   = '0;
            o_last_next = 1'b1;
            o_mode_next = mode_next;
            o_fill_next = count_reg;
            o_drop_next = 1'b0;
        end

        if (cmd.play_chk)
        begin
            hit_next = 1'b0;
            if (mode_reg == MODE_DEPLETED)
            begin
                mode_next = MODE_DEPLETED;
            end
            else if (rvalid_reg && (ofs_reg < OFS_W'(len_q)))
            begin
                hit_next = 1'b1;
                ofs_next = ofs_reg + 1'b1;
            end
            else if (count_reg != '0)
            begin
                head_next   = head_inc;
                count_next  = count_reg - 1'b1;
                rvalid_next = 1'b1;
                rd_slot     = head_reg;
                rd_ofs      = '0;
                hit_next    = 1'b1;
                ofs_next    = OFS_W'(1);
            end
            else
            begin
                ofs_next    = '0;
                rvalid_next = 1'b0;
                mode_next   = MODE_DEPLETED;
            end
        end

        if (cmd.play_cap)
        begin
            if (hit_reg)
            begin
                held_next[j_reg] = {st_rdata[7:0], st_rdata[15:8]};
            end
            j_next = status.ch_last ? '0 : j_reg + 1'b1;
        end

        if (cmd.play_adj && (mode_reg != MODE_NORMAL))
        begin
            if (count_reg < CNT_W'(TH_DEPLETED))
            begin
                mode_next = MODE_DEPLETED;
            end
            else if (count_reg < CNT_W'(TH_UNDER_PLAY))
            begin
                if (mode_reg != MODE_DEPLETED)
                begin
                    mode_next = MODE_UNDER;
                end
            end
            else if (count_reg > CNT_W'(TH_OVER_PLAY))
            begin
                mode_next = MODE_OVER;
            end
            else
            begin
                mode_next = MODE_NORMAL;
            end
            if (!adj_reg)
            begin
                adj_next = 1'b1;
                if (mode_next == MODE_OVER)
                begin
                    ofs_next = ofs_reg + OFS_W'(nc);
                end
                else if (mode_next == MODE_UNDER)
                begin
                    ofs_next = (ofs_reg >= OFS_W'(nc)) ? ofs_reg - OFS_W'(nc) : '0;
                end
            end
        end

        if (cmd.emit)
        begin
            j_next = j_reg + 1'b1;
            if (sel_mask[j_reg])
            begin
                ov_next     = 1'b1;
                o_kind_next = KIND_AUDIO;
                o_smp_next  = held_reg[j_reg];
                o_ch_next   = j_reg;
                o_last_next = ((sel_mask >> j_reg) >> 1) == '0;
                o_mode_next = mode_reg;
                o_fill_next = count_reg;
                o_drop_next = 1'b0;
            end
        end
    end

    assign status.cmd      = cmd_reg;
    assign status.eop      = eop_reg;
    assign status.ch_last  = (NC_W'(j_reg) == nc - 1'b1);
    assign status.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            word_reg <= in_sample_word;
            eop_reg  <= in_end_of_packet;
        end
        o_kind_reg <= o_kind_next;
        o_smp_reg  <= o_smp_next;
        o_ch_reg   <= o_ch_next;
        o_last_reg <= o_last_next;
        o_mode_reg <= o_mode_next;
        o_fill_reg <= o_fill_next;
        o_drop_reg <= o_drop_next;
        hit_reg    <= hit_next;
        j_reg      <= j_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= NC_W'(2);
            channel_mask_reg <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            wpos_reg         <= '0;
            ofs_reg          <= '0;
            rvalid_reg       <= 1'b0;
            mode_reg         <= MODE_NORMAL;
            adj_reg          <= 1'b0;
            ov_reg           <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_en && (wr_index == REG_NUM_CHANNELS))
            begin
                num_channels_reg <= wr_data[NC_W-1:0];
            end
            if (wr_en && (wr_index == REG_CHANNEL_MASK))
            begin
                channel_mask_reg <= wr_data;
            end
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            wpos_reg   <= wpos_next;
            ofs_reg    <= ofs_next;
            rvalid_reg <= rvalid_next;
            mode_reg   <= mode_next;
            adj_reg    <= adj_next;
            ov_reg     <= ov_next;
            held_reg   <= held_next;
        end
    end

    assign out_valid          = ov_reg;
    assign out_kind           = o_kind_reg;
    assign out_audio_sample   = o_smp_reg;
    assign out_channel_index  = o_ch_reg;
    assign out_last           = o_last_reg;
    assign out_play_state     = o_mode_reg;
    assign out_fill_level     = o_fill_reg;
    assign out_packet_dropped = o_drop_reg;
endmodule

/* rtl/audio_jitter_buffer_playout_top.sv */
// audio_jitter_buffer_playout_top: top level of the playout jitter buffer
// depends on ajb_pkg, ajb_in_if, ajb_out_if, ajb_ctrl, ajb_dp
//
// in_ch takes one word per item: cmd 0 writes a network-order sample into the tail
// packet (end_of_packet commits it), cmd 1 opens a playback period, cmd 2 plays a frame.
// out_ch returns the result words: one commit status per end_of_packet word, one period
// status per period start, and one audio word per selected channel of a played frame,
// with last set on the final word of the item.
// wr_en/wr_index/wr_data write num_channels (index 0) and channel_mask (index 1); the
// user must do so only while the block is idle; the block does not enforce this.
// one item at a time: in_ch.ready is high only when idle.
// write or period item: after LEN, the WRITE or PERIOD state registers the result word.
// play item: after LEN, CHK and CAP step through N channels (one sample store read
// and one hold update per channel), then ADJ, then EMIT visits each channel slot.
// a stalled out_ch holds the result register and the sequencer waits on it.
// reset empties the ring, clears held samples to zero, mode normal, num_channels 2,
// channel_mask 0; the sample and length stores are not cleared.
module audio_jitter_buffer_playout_top (
    input  logic                        clk,
    input  logic                        rst_n,
    ajb_in_if.sink                      in_ch,
    ajb_out_if.source                   out_ch,
    input  logic                        wr_en,
    input  logic [ajb_pkg::IDX_W-1:0]   wr_index,
    input  logic [ajb_pkg::DATA_W-1:0]  wr_data
);
    import ajb_pkg::*;

    ajb_cmd_t    cmd;
    ajb_status_t status;

    ajb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ajb_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .in_cmd             (in_ch.cmd),
        .in_sample_word     (in_ch.sample_word),
        .in_end_of_packet   (in_ch.end_of_packet),
        .wr_en              (wr_en),
        .wr_index           (wr_index),
        .wr_data            (wr_data),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .out_kind           (out_ch.kind),
        .out_audio_sample   (out_ch.audio_sample),
        .out_channel_index  (out_ch.channel_index),
        .out_last           (out_ch.last),
        .out_play_state     (out_ch.play_state),
        .out_fill_level     (out_ch.fill_level),
        .out_packet_dropped (out_ch.packet_dropped)
    );

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.fill_level < 7'(NUM_PKTS)))
        else $error("fill level beyond ring capacity");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.kind != KIND_AUDIO)) |->
        ((out_ch.audio_sample == '0) && (out_ch.channel_index == '0) && out_ch.last))
        else $error("status word carries audio payload");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("second item taken while busy");
`endif
endmodule
